FILE: rtl/assert_macros.svh
// assertion macros used by the rtl top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, disabled while reset is asserted
`define CAS_ASSERT(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// clocked assertion that also holds during reset
`define CAS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/cas_pkg.sv
// types, codes and helper functions of the cigar alignment scorer
`default_nettype none

package cas_pkg;

	localparam int CNT_W   = 11;
	localparam int LEN_W   = 12;
	localparam int ACC_W   = 20;
	localparam int DELTA_W = 24;
	localparam int PROD_W  = 22;

	// item opcodes
	localparam logic [1:0] OP_MATCH  = 2'd0;
	localparam logic [1:0] OP_INSERT = 2'd1;
	localparam logic [1:0] OP_DELETE = 2'd2;
	localparam logic [1:0] OP_FINISH = 2'd3;

	// scoring modes, the spare code behaves as very fast
	localparam logic [1:0] MODE_BELOW_FAST = 2'd0;
	localparam logic [1:0] MODE_FAST       = 2'd1;
	localparam logic [1:0] MODE_VERY_FAST  = 2'd2;
	localparam logic [1:0] MODE_VERY_ALT   = 2'd3;

	// register indexes
	localparam logic [2:0] REG_SCORE_MODE     = 3'd0;
	localparam logic [2:0] REG_MATCH_REWARD   = 3'd1;
	localparam logic [2:0] REG_MISMATCH_COST  = 3'd2;
	localparam logic [2:0] REG_MATCH_COL      = 3'd3;
	localparam logic [2:0] REG_MISMATCH_COL   = 3'd4;
	localparam logic [2:0] REG_GAP_OPEN       = 3'd5;
	localparam logic [2:0] REG_GAP_EXTEND     = 3'd6;

	localparam logic [7:0] FIXED_GAP_OPEN = 8'd40;
	localparam logic [7:0] FIXED_GAP_EXT  = 8'd6;

	localparam logic signed [DELTA_W:0] ACC_MAX = (DELTA_W+1)'(524287);
	localparam logic signed [DELTA_W:0] ACC_MIN = -(DELTA_W+1)'(524288);

	typedef struct packed {
		logic [1:0]  opcode;
		logic [1:0]  ref_base;
		logic [1:0]  read_base;
		logic [10:0] run_length;
		logic [10:0] read_length;
	} cmd_t;

	typedef struct packed {
		logic [CNT_W-1:0]        match_columns;
		logic [CNT_W-1:0]        mismatch_count;
		logic [CNT_W-1:0]        inserted_bases;
		logic [CNT_W-1:0]        indel_runs;
		logic [LEN_W-1:0]        aligned_length;
		logic signed [ACC_W-1:0] primary_score;
		logic signed [ACC_W-1:0] secondary_score;
		logic                    length_error;
	} res_t;

	typedef struct packed {
		logic [2:0] addr;
		logic [8:0] value;
	} cfg_t;

	function automatic logic signed [ACC_W-1:0] sat_acc(
		input logic signed [ACC_W-1:0]   acc,
		input logic signed [DELTA_W-1:0] delta
	);
		logic signed [DELTA_W:0] sum;
		logic signed [ACC_W-1:0] res;
		sum = {{(DELTA_W+1-ACC_W){acc[ACC_W-1]}}, acc} + {delta[DELTA_W-1], delta};
		if (sum > ACC_MAX) begin
			res = ACC_MAX[ACC_W-1:0];
		end else if (sum < ACC_MIN) begin
			res = ACC_MIN[ACC_W-1:0];
		end else begin
			res = sum[ACC_W-1:0];
		end
		return res;
	endfunction

	function automatic logic [CNT_W-1:0] sat_cnt(
		input logic [CNT_W-1:0] cur,
		input logic [CNT_W-1:0] delta
	);
		logic [CNT_W:0] sum;
		sum = {1'b0, cur} + {1'b0, delta};
		return sum[CNT_W] ? {CNT_W{1'b1}} : sum[CNT_W-1:0];
	endfunction

	function automatic logic [LEN_W-1:0] sat_len(
		input logic [LEN_W-1:0] cur,
		input logic [CNT_W-1:0] delta
	);
		logic [LEN_W:0] sum;
		sum = {1'b0, cur} + {{(LEN_W+1-CNT_W){1'b0}}, delta};
		return sum[LEN_W] ? {LEN_W{1'b1}} : sum[LEN_W-1:0];
	endfunction

endpackage

`default_nettype wire

FILE: rtl/cas_stream_if.sv
// valid/ready channel carrying one payload item
`default_nettype none

interface cas_stream_if #(parameter type T = logic);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: rtl/cigar_alignment_scorer.sv
// cigar alignment scorer top level: counters, score accumulators and result register
//
// usage
//   cmd: one item per cigar element, a match column, an insertion run, a deletion
//     run or a finish item that carries the read length
//   res: one item per finish, the counts and both scores of the alignment
//   cfg: register writes (index, value), always ready, written while idle
// timing
//   an accepted item sits in the input register, where one shared
//   gap multiplier and the saturating adders update the running state
//   a finish item moves from the input register to the result register behind res
//   throughput is one item per cycle while no finish item waits on a held result
// reset
//   arst_n clears counters, accumulators and valid flags and loads the
//   register defaults; the block is ready in the first cycle after reset
// stalls
//   while a result waits on res, columns and runs keep flowing; a following
//   finish item holds in the input register and drops cmd.ready until the
//   waiting result is taken
`default_nettype none
`include "assert_macros.svh"

module cigar_alignment_scorer #(
	parameter int MAX_READ_LEN = 1024
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	cas_stream_if.sink     cmd,
	cas_stream_if.source   res,
	cas_stream_if.sink     cfg
);

	// effective read length limit, read_length is only 11 bits wide
	localparam int LIM = (MAX_READ_LEN > 2047) ? 2047 : MAX_READ_LEN;
	localparam logic [10:0] LEN_LIMIT = 11'(LIM);

	// configuration registers
	logic [1:0]        score_mode_q;
	logic [7:0]        match_reward_q;
	logic [7:0]        mismatch_cost_q;
	logic signed [8:0] match_col_q;
	logic signed [8:0] mismatch_col_q;
	logic [7:0]        gap_open_q;
	logic [7:0]        gap_extend_q;

	// input register
	logic          valid_s1;
	cas_pkg::cmd_t cmd_s1;

	// running state
	logic [cas_pkg::CNT_W-1:0]        match_total_q;
	logic [cas_pkg::CNT_W-1:0]        mismatch_total_q;
	logic [cas_pkg::CNT_W-1:0]        insert_total_q;
	logic [cas_pkg::CNT_W-1:0]        indel_total_q;
	logic [cas_pkg::LEN_W-1:0]        length_total_q;
	logic signed [cas_pkg::ACC_W-1:0] score_acc_q;
	logic signed [cas_pkg::ACC_W-1:0] second_acc_q;

	// result register
	logic          res_valid_q;
	cas_pkg::res_t res_data_q;

	// next-state logic
	logic                               s1_fin, is_col, is_ins, is_run, mism;
	logic                               out_free, s1_go;
	logic                               fixed_gap, very_fast;
	logic [10:0]                        eff_len;
	logic [cas_pkg::LEN_W-1:0]          eff_len_w, tail_gap;
	logic                               need_tail, len_err, charge_gap;
	logic signed [12:0]                 mul_a;
	logic signed [8:0]                  mul_b;
	logic signed [cas_pkg::PROD_W-1:0]  prod;
	logic [7:0]                         open_w;
	logic signed [cas_pkg::DELTA_W-1:0] gap_cost, delta_score, delta_second;
	logic [cas_pkg::CNT_W-1:0]          match_nxt, mismatch_nxt, insert_nxt, indel_nxt;
	logic [cas_pkg::LEN_W-1:0]          length_nxt;
	logic signed [cas_pkg::ACC_W-1:0]   score_nxt, second_nxt;

	// handshakes
	assign s1_fin    = (cmd_s1.opcode == cas_pkg::OP_FINISH);
	assign out_free  = !res_valid_q || res.ready;
	// only a finish item needs the result register
	assign s1_go     = valid_s1 && (!s1_fin || out_free);
	assign cmd.ready = !valid_s1 || s1_go;
	assign cfg.ready = 1'b1;
	assign res.valid = res_valid_q;
	assign res.data  = res_data_q;

	// mode decode, the spare mode code acts as very fast
	assign fixed_gap = (score_mode_q != cas_pkg::MODE_BELOW_FAST);
	assign very_fast = (score_mode_q == cas_pkg::MODE_VERY_FAST) ||
		(score_mode_q == cas_pkg::MODE_VERY_ALT);

	always_comb begin
		is_col = (cmd_s1.opcode == cas_pkg::OP_MATCH);
		is_ins = (cmd_s1.opcode == cas_pkg::OP_INSERT);
		is_run = is_ins || (cmd_s1.opcode == cas_pkg::OP_DELETE);
		mism   = (cmd_s1.ref_base != cmd_s1.read_base);

		// finish: clamp the read length and find the unaligned tail
		eff_len   = (cmd_s1.read_length > LEN_LIMIT) ? LEN_LIMIT : cmd_s1.read_length;
		eff_len_w = {1'b0, eff_len};
		need_tail = (length_total_q < eff_len_w);
		len_err   = (length_total_q > eff_len_w);
		tail_gap  = eff_len_w - length_total_q;

		// one multiplier serves both gap runs and the tail penalty
		// below fast charges a run as open + (len-1)*ext, a zero run gives open - ext
		if (is_run) begin
			mul_a = fixed_gap ? $signed({2'b00, cmd_s1.run_length})
				: $signed({2'b00, cmd_s1.run_length}) - 13'sd1;
		end else begin
			mul_a = $signed({1'b0, tail_gap});
		end
		mul_b    = fixed_gap ? $signed({1'b0, cas_pkg::FIXED_GAP_EXT})
			: $signed({1'b0, gap_extend_q});
		prod     = mul_a * mul_b;
		open_w   = fixed_gap ? cas_pkg::FIXED_GAP_OPEN : gap_open_q;
		gap_cost = {{(cas_pkg::DELTA_W-cas_pkg::PROD_W){prod[cas_pkg::PROD_W-1]}}, prod}
			+ $signed({{(cas_pkg::DELTA_W-8){1'b0}}, open_w});

		charge_gap   = is_run || (s1_fin && need_tail);
		delta_score  = '0;
		delta_second = '0;
		if (is_col) begin
			if (very_fast) begin
				delta_second = mism
					? -$signed({{(cas_pkg::DELTA_W-8){1'b0}}, mismatch_cost_q})
					: $signed({{(cas_pkg::DELTA_W-8){1'b0}}, match_reward_q});
			end else begin
				delta_score = mism
					? {{(cas_pkg::DELTA_W-9){mismatch_col_q[8]}}, mismatch_col_q}
					: {{(cas_pkg::DELTA_W-9){match_col_q[8]}}, match_col_q};
			end
		end
		if (charge_gap) begin
			if (fixed_gap) begin
				delta_score = gap_cost;
			end else begin
				delta_second = -gap_cost;
			end
		end
		score_nxt  = cas_pkg::sat_acc(score_acc_q, delta_score);
		second_nxt = cas_pkg::sat_acc(second_acc_q, delta_second);

		// saturating counters
		match_nxt    = is_col ? cas_pkg::sat_cnt(match_total_q, 11'd1) : match_total_q;
		mismatch_nxt = (is_col && mism) ? cas_pkg::sat_cnt(mismatch_total_q, 11'd1)
			: mismatch_total_q;
		insert_nxt   = is_ins ? cas_pkg::sat_cnt(insert_total_q, cmd_s1.run_length)
			: insert_total_q;
		indel_nxt    = is_run ? cas_pkg::sat_cnt(indel_total_q, 11'd1) : indel_total_q;
		if (is_col) begin
			length_nxt = cas_pkg::sat_len(length_total_q, 11'd1);
		end else if (is_ins) begin
			length_nxt = cas_pkg::sat_len(length_total_q, cmd_s1.run_length);
		end else begin
			length_nxt = length_total_q;
		end
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			score_mode_q    <= cas_pkg::MODE_BELOW_FAST;
			match_reward_q  <= 8'd2;
			mismatch_cost_q <= 8'd6;
			match_col_q     <= 9'sd0;
			mismatch_col_q  <= 9'sd6;
			gap_open_q      <= 8'd40;
			gap_extend_q    <= 8'd6;
		end else if (cfg.valid) begin
			unique case (cfg.data.addr)
				cas_pkg::REG_SCORE_MODE:    score_mode_q    <= cfg.data.value[1:0];
				cas_pkg::REG_MATCH_REWARD:  match_reward_q  <= cfg.data.value[7:0];
				cas_pkg::REG_MISMATCH_COST: mismatch_cost_q <= cfg.data.value[7:0];
				cas_pkg::REG_MATCH_COL:     match_col_q     <= $signed(cfg.data.value);
				cas_pkg::REG_MISMATCH_COL:  mismatch_col_q  <= $signed(cfg.data.value);
				cas_pkg::REG_GAP_OPEN:      gap_open_q      <= cfg.data.value[7:0];
				cas_pkg::REG_GAP_EXTEND:    gap_extend_q    <= cfg.data.value[7:0];
				default: begin
				end
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd.ready) begin
			valid_s1 <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) begin
			cmd_s1 <= cmd.data;
		end
	end

	// running state, cleared by a finish item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_total_q    <= '0;
			mismatch_total_q <= '0;
			insert_total_q   <= '0;
			indel_total_q    <= '0;
			length_total_q   <= '0;
			score_acc_q      <= '0;
			second_acc_q     <= '0;
		end else if (s1_go) begin
			if (s1_fin) begin
				match_total_q    <= '0;
				mismatch_total_q <= '0;
				insert_total_q   <= '0;
				indel_total_q    <= '0;
				length_total_q   <= '0;
				score_acc_q      <= '0;
				second_acc_q     <= '0;
			end else begin
				match_total_q    <= match_nxt;
				mismatch_total_q <= mismatch_nxt;
				insert_total_q   <= insert_nxt;
				indel_total_q    <= indel_nxt;
				length_total_q   <= length_nxt;
				score_acc_q      <= score_nxt;
				second_acc_q     <= second_nxt;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (s1_go && s1_fin) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go && s1_fin) begin
			res_data_q.match_columns   <= match_total_q;
			res_data_q.mismatch_count  <= mismatch_total_q;
			res_data_q.inserted_bases  <= insert_total_q;
			res_data_q.indel_runs      <= indel_total_q;
			res_data_q.aligned_length  <= length_total_q;
			res_data_q.primary_score   <= score_nxt;
			res_data_q.secondary_score <= second_nxt;
			res_data_q.length_error    <= len_err;
		end
	end

	// checks
	`CAS_ASSERT(a_finish_gives_result, clk, arst_n,
		(s1_go && s1_fin) |=> res.valid, "finish item did not produce a result")
	`CAS_ASSERT(a_finish_clears, clk, arst_n,
		(s1_go && s1_fin) |=> (length_total_q == '0 && score_acc_q == '0 && second_acc_q == '0),
		"state not cleared after finish")
	`CAS_ASSERT(a_count_order, clk, arst_n,
		(mismatch_total_q <= match_total_q) && (length_total_q >= {1'b0, match_total_q})
		&& (length_total_q >= {1'b0, insert_total_q}), "inconsistent counters")
	`CAS_ASSERT(a_stall_cause, clk, arst_n,
		!cmd.ready |-> (valid_s1 && s1_fin && res_valid_q && !res.ready),
		"input stalled without a waiting result")

endmodule

`default_nettype wire
